// ----- src/mtbs_pkg.sv -----
// ----------------------------------------------------------------------------
// mtbs_pkg
// Shared sizes and codes for the modular back substitution core.
// ----------------------------------------------------------------------------
package mtbs_pkg;

    localparam int MAX_SIZE    = 8;
    localparam int MAX_COLUMNS = 8;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;   // holds 0..8
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int STEP_W      = 5;   // bit counter of the shared unit

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  idx_t;

    // opcodes
    localparam logic [1:0] OP_WRITE_U = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_SOLVE   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MODULUS = 2'd0;
    localparam logic [1:0] CFG_UNIT    = 2'd1;
    localparam logic [1:0] CFG_SIZE    = 2'd2;
    localparam logic [1:0] CFG_COLS    = 2'd3;

endpackage

// ----- src/modular_triangular_back_substitution_core.sv -----
// ----------------------------------------------------------------------------
// modular_triangular_back_substitution_core
// Solves U*X = B mod n for upper triangular U with one shared shift/subtract unit.
// ----------------------------------------------------------------------------
// Load transactions (write U / write B) are accepted back to back while idle.
// A solve makes one pass of the shared unit per multiply or division.
// Inverse phase: per diagonal a reduction mod n, then Euclid rounds (division,
// multiply). Each X entry: a multiply per term right of the diagonal, B reduced,
// times the inverse unless unit diagonal; s_tready is low for the whole solve.
// rst_n (async, active low) clears control and config (n 2, unit 0, 8, 8).
module modular_triangular_back_substitution_core
    import mtbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] row_index, [5:3] col_index, [37:6] entry_value
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] out_row, [5:3] out_col, [37:6] out_value
    output logic [0:0]  m_tuser,   // [0] not_invertible
    output logic        m_tlast,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // sequencer codes
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_RUN       = 5'd1;
    localparam logic [4:0] S_INV_RD    = 5'd2;
    localparam logic [4:0] S_INV_RED   = 5'd3;
    localparam logic [4:0] S_INV_R1    = 5'd4;
    localparam logic [4:0] S_EU_CHK    = 5'd5;
    localparam logic [4:0] S_EU_DIV    = 5'd6;
    localparam logic [4:0] S_EU_T      = 5'd7;
    localparam logic [4:0] S_COL_START = 5'd8;
    localparam logic [4:0] S_ROW_START = 5'd9;
    localparam logic [4:0] S_DOT_RD    = 5'd10;
    localparam logic [4:0] S_DOT_GO    = 5'd11;
    localparam logic [4:0] S_DOT_ACC   = 5'd12;
    localparam logic [4:0] S_B_RD      = 5'd13;
    localparam logic [4:0] S_B_GO      = 5'd14;
    localparam logic [4:0] S_B_SUB     = 5'd15;
    localparam logic [4:0] S_X_WR      = 5'd16;
    localparam logic [4:0] S_ROW_DONE  = 5'd17;
    localparam logic [4:0] S_EMIT      = 5'd18;

    // configuration registers
    word_t            modulus_reg;
    logic             unit_reg;
    logic [CNT_W-1:0] size_reg;
    logic [CNT_W-1:0] cols_reg;

    // sequencer state
    logic [4:0]       state_reg, state_next;
    logic [4:0]       ret_reg, ret_next;
    logic [CNT_W-1:0] i_reg, i_next;
    idx_t             j_reg, j_next;
    idx_t             k_reg, k_next;
    logic [CNT_W-1:0] sz_reg, sz_next;
    logic [CNT_W-1:0] nc_reg, nc_next;
    word_t            n_reg, n_next;
    logic             bad_reg, bad_next;
    logic             unitd_reg, unitd_next;
    logic             invph_reg, invph_next;

    // shared shift/subtract unit
    word_t            acc_reg, acc_next;
    word_t            mx_reg, mx_next;
    word_t            my_reg, my_next;
    logic             div_reg, div_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    // Euclid and dot product working registers
    word_t r0_reg, r0_next, r1_reg, r1_next;
    word_t t0_reg, t0_next, t1_reg, t1_next;
    word_t s_reg, s_next;

    word_t inv_reg [MAX_SIZE];
    word_t xs_reg  [MAX_SIZE];
    logic  inv_we, xs_we;
    word_t inv_wd, xs_wd;

    // output register
    logic        ov_reg, ov_next;
    idx_t        orow_reg, orow_next, ocol_reg, ocol_next;
    word_t       oval_reg, oval_next;
    logic        obad_reg, obad_next, olast_reg, olast_next;

    // stores
    word_t u_mem [MAX_SIZE*MAX_SIZE];
    word_t b_mem [MAX_SIZE*MAX_COLUMNS];
    word_t u_rd_reg, b_rd_reg;
    logic [ADDR_W-1:0] u_addr, b_addr;

    logic  s_acc;
    logic  [1:0] in_op;
    idx_t  in_row, in_col;
    word_t in_val;

    assign in_op  = s_tuser;
    assign in_row = s_tdata[2:0];
    assign in_col = s_tdata[5:3];
    assign in_val = s_tdata[37:6];
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, oval_reg, ocol_reg, orow_reg};
    assign m_tuser  = obad_reg;
    assign m_tlast  = olast_reg;

    // diagonal entry during inverse phase, row j entries during the dot product
    assign u_addr = invph_reg ? {i_reg[IDX_W-1:0], i_reg[IDX_W-1:0]}
                              : {j_reg, i_reg[IDX_W-1:0]};
    assign b_addr = {j_reg, k_reg};

    always_ff @(posedge clk)
    begin
        if (s_acc && in_op == OP_WRITE_U)
        begin
            u_mem[{in_row, in_col}] <= in_val;
        end
        if (s_acc && in_op == OP_WRITE_B)
        begin
            b_mem[{in_row, in_col}] <= in_val;
        end
        u_rd_reg <= u_mem[u_addr];
        b_rd_reg <= b_mem[b_addr];
        if (inv_we)
        begin
            inv_reg[i_reg[IDX_W-1:0]] <= inv_wd;
        end
        if (xs_we)
        begin
            xs_reg[j_reg] <= xs_wd;
        end
    end

    // Shared unit step. Division: shift in dividend MSB, compare/subtract
    // divisor r1, quotient bit into mx. Mulmod: double mod n, then add y mod n when the top bit of x is set.
    word_t           m_op, u_half, u_res, u_add;
    logic [WORD_W:0] u_t, u_t2;
    logic            u_ge;
    assign m_op   = div_reg ? r1_reg : n_reg;
    assign u_t    = {acc_reg, div_reg & mx_reg[WORD_W-1]};
    assign u_ge   = u_t >= {1'b0, m_op};
    assign u_half = u_ge ? WORD_W'(u_t - {1'b0, m_op}) : u_t[WORD_W-1:0];
    assign u_add  = mx_reg[WORD_W-1] ? my_reg : '0;
    assign u_t2   = {1'b0, u_half} + {1'b0, u_add};
    assign u_res  = (u_t2 >= {1'b0, n_reg}) ? WORD_W'(u_t2 - {1'b0, n_reg})
                                              : u_t2[WORD_W-1:0];

    logic [WORD_W:0] sum33, sub33;
    word_t           eu_t2;
    logic [CNT_W-1:0] j_ext, k_ext;
    assign j_ext = {1'b0, j_reg};
    assign k_ext = {1'b0, k_reg};

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg;
        sz_next = sz_reg; nc_next = nc_reg; n_next = n_reg;
        bad_next = bad_reg; unitd_next = unitd_reg; invph_next = invph_reg;
        acc_next = acc_reg; mx_next = mx_reg; my_next = my_reg;
        div_next = div_reg; cnt_next = cnt_reg;
        r0_next = r0_reg; r1_next = r1_reg; t0_next = t0_reg; t1_next = t1_reg;
        s_next = s_reg;
        inv_we = 1'b0; inv_wd = '0; xs_we = 1'b0; xs_wd = '0;
        ov_next = ov_reg && !m_tready;
        orow_next = orow_reg; ocol_next = ocol_reg; oval_next = oval_reg;
        obad_next = obad_reg; olast_next = olast_reg;
        sum33 = '0; sub33 = '0; eu_t2 = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_acc && in_op == OP_SOLVE)
                begin
                    n_next  = (modulus_reg < 32'd2) ? 32'd2 : modulus_reg;
                    sz_next = (size_reg == '0) ? CNT_W'(1)
                            : (size_reg > CNT_W'(MAX_SIZE)) ? CNT_W'(MAX_SIZE) : size_reg;
                    nc_next = (cols_reg == '0) ? CNT_W'(1)
                            : (cols_reg > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : cols_reg;
                    unitd_next = unit_reg;
                    invph_next = !unit_reg;
                    bad_next = 1'b0;
                    i_next = '0;
                    k_next = '0;
                    state_next = unit_reg ? S_COL_START : S_INV_RD;
                end
            end
            S_RUN:
            begin
                acc_next = div_reg ? u_half : u_res;
                mx_next  = {mx_reg[WORD_W-2:0], div_reg & u_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(WORD_W - 1))
                begin
                    state_next = ret_reg;
                end
            end
            S_INV_RD:
            begin
                state_next = S_INV_RED;
            end
            S_INV_RED:
            begin
                acc_next = '0; mx_next = u_rd_reg; my_next = 32'd1;
                div_next = 1'b0; cnt_next = '0;
                ret_next = S_INV_R1; state_next = S_RUN;
            end
            S_INV_R1:
            begin
                r0_next = n_reg; r1_next = acc_reg;
                t0_next = '0; t1_next = 32'd1;
                state_next = S_EU_CHK;
            end
            S_EU_CHK:
            begin
                if (r1_reg == '0)
                begin
                    inv_we = 1'b1;
                    inv_wd = (r0_reg == 32'd1) ? t0_reg : '0;
                    if (r0_reg != 32'd1)
                    begin
                        bad_next = 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                    state_next = (i_reg + 1'b1 == sz_reg) ? S_COL_START : S_INV_RD;
                end
                else
                begin
                    acc_next = '0; mx_next = r0_reg; div_next = 1'b1; cnt_next = '0;
                    ret_next = S_EU_DIV; state_next = S_RUN;
                end
            end
            S_EU_DIV:
            begin
                // mx holds the quotient, acc the remainder
                r0_next = r1_reg; r1_next = acc_reg;
                acc_next = '0; my_next = t1_reg; div_next = 1'b0; cnt_next = '0;
                ret_next = S_EU_T; state_next = S_RUN;
            end
            S_EU_T:
            begin
                sub33 = {1'b0, t0_reg} - {1'b0, acc_reg};
                eu_t2 = sub33[WORD_W] ? WORD_W'(sub33 + {1'b0, n_reg}) : sub33[WORD_W-1:0];
                t0_next = t1_reg; t1_next = eu_t2;
                state_next = S_EU_CHK;
            end
            S_COL_START:
            begin
                invph_next = 1'b0;
                j_next = IDX_W'(sz_reg - 1'b1);
                state_next = S_ROW_START;
            end
            S_ROW_START:
            begin
                s_next = '0;
                i_next = j_ext + 1'b1;
                state_next = (j_ext + 1'b1 == sz_reg) ? S_B_RD : S_DOT_RD;
            end
            S_DOT_RD:
            begin
                state_next = S_DOT_GO;
            end
            S_DOT_GO:
            begin
                acc_next = '0; mx_next = u_rd_reg; my_next = xs_reg[i_reg[IDX_W-1:0]];
                div_next = 1'b0; cnt_next = '0;
                ret_next = S_DOT_ACC; state_next = S_RUN;
            end
            S_DOT_ACC:
            begin
                sum33 = {1'b0, s_reg} + {1'b0, acc_reg};
                s_next = (sum33 >= {1'b0, n_reg}) ? WORD_W'(sum33 - {1'b0, n_reg})
                                                   : sum33[WORD_W-1:0];
                i_next = i_reg + 1'b1;
                state_next = (i_reg + 1'b1 == sz_reg) ? S_B_RD : S_DOT_RD;
            end
            S_B_RD:
            begin
                state_next = S_B_GO;
            end
            S_B_GO:
            begin
                acc_next = '0; mx_next = b_rd_reg; my_next = 32'd1;
                div_next = 1'b0; cnt_next = '0;
                ret_next = S_B_SUB; state_next = S_RUN;
            end
            S_B_SUB:
            begin
                sub33 = {1'b0, acc_reg} - {1'b0, s_reg};
                eu_t2 = sub33[WORD_W] ? WORD_W'(sub33 + {1'b0, n_reg}) : sub33[WORD_W-1:0];
                if (unitd_reg)
                begin
                    xs_we = 1'b1; xs_wd = eu_t2;
                    state_next = S_ROW_DONE;
                end
                else
                begin
                    acc_next = '0; mx_next = eu_t2; my_next = inv_reg[j_reg];
                    div_next = 1'b0; cnt_next = '0;
                    ret_next = S_X_WR; state_next = S_RUN;
                end
            end
            S_X_WR:
            begin
                xs_we = 1'b1; xs_wd = acc_reg;
                state_next = S_ROW_DONE;
            end
            S_ROW_DONE:
            begin
                if (j_reg == '0)
                begin
                    i_next = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    j_next = j_reg - 1'b1;
                    state_next = S_ROW_START;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    orow_next  = i_reg[IDX_W-1:0];
                    ocol_next  = k_reg;
                    oval_next  = xs_reg[i_reg[IDX_W-1:0]];
                    obad_next  = bad_reg;
                    olast_next = (k_ext + 1'b1 == nc_reg) && (i_reg + 1'b1 == sz_reg);
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 == sz_reg)
                    begin
                        if (k_ext + 1'b1 == nc_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                            state_next = S_COL_START;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ov_reg      <= 1'b0;
            modulus_reg <= 32'd2;
            unit_reg    <= 1'b0;
            size_reg    <= CNT_W'(MAX_SIZE);
            cols_reg    <= CNT_W'(MAX_COLUMNS);
            invph_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            invph_reg <= invph_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODULUS: modulus_reg <= cfg_data;
                    CFG_UNIT:    unit_reg    <= cfg_data[0];
                    CFG_SIZE:    size_reg    <= cfg_data[CNT_W-1:0];
                    CFG_COLS:    cols_reg    <= cfg_data[CNT_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        ret_reg <= ret_next;
        i_reg <= i_next; j_reg <= j_next; k_reg <= k_next;
        sz_reg <= sz_next; nc_reg <= nc_next; n_reg <= n_next;
        bad_reg <= bad_next; unitd_reg <= unitd_next;
        acc_reg <= acc_next; mx_reg <= mx_next; my_reg <= my_next;
        div_reg <= div_next; cnt_reg <= cnt_next;
        r0_reg <= r0_next; r1_reg <= r1_next; t0_reg <= t0_next; t1_reg <= t1_next;
        s_reg <= s_next;
        orow_reg <= orow_next; ocol_reg <= ocol_next; oval_reg <= oval_next;
        obad_reg <= obad_next; olast_reg <= olast_next;
    end

    // modular multiply keeps its accumulator reduced
    a_mul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && !div_reg) |-> (acc_reg < n_reg))
        else $error("mulmod accumulator not below modulus");

    // dot product partial sum stays reduced
    a_sum_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOT_RD) |-> (s_reg < n_reg))
        else $error("dot product sum not below modulus");

    // row counter inside the used size
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW_START) |-> (j_ext < sz_reg))
        else $error("row index past size");

    // final result returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && state_next != S_EMIT && olast_next) |=> (state_reg == S_IDLE))
        else $error("last result without return to idle");

endmodule
